/* design/prq_pkg.sv */
// Shared types, constants and helper functions for the packet ring queue.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package prq_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam int CNT_W   = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_RESET = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 1'b0,
    REG_MAX_ADDRESS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_BAD_ADDR = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] seq;
    logic [7:0]  hop;
  } slot_t;

  typedef struct packed {
    logic [CAP_W-1:0]  eff_cap;
    logic [ADDR_W-1:0] max_addr;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    slot_t       pkt;
  } op_t;

  typedef struct packed {
    status_e           status;
    slot_t             pkt;
    logic [CAP_W-1:0]  occupancy;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_count;
  } res_t;

  function automatic logic addr_ok(input logic [7:0] a, input logic [ADDR_W-1:0] max_addr);
    return !a[7] && (a[ADDR_W-1:0] <= max_addr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                   input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= cap) ? '0 : PTR_W'(n);
  endfunction

endpackage

`default_nettype wire

/* design/prq_cfg_regs.sv */
// Configuration registers of the packet ring queue: capacity and largest address.
// Clamps the capacity to between one and the built depth. Depends on prq_pkg.
`default_nettype none

module prq_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [prq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [prq_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output prq_pkg::cfg_t                        cfg_o
);
  import prq_pkg::*;

  logic [CAP_W-1:0]  capacity_q, capacity_d;
  logic [ADDR_W-1:0] max_addr_q, max_addr_d;

  always_comb begin
    capacity_d = capacity_q;
    max_addr_d = max_addr_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CAPACITY:    capacity_d = cfg_wdata_i[CAP_W-1:0];
        REG_MAX_ADDRESS: max_addr_d = cfg_wdata_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      max_addr_q <= ADDR_RESET;
    end else begin
      capacity_q <= capacity_d;
      max_addr_q <= max_addr_d;
    end
  end

  always_comb begin
    if (capacity_q == '0) begin
      cfg_o.eff_cap = CAP_W'(1);
    end else if (capacity_q > CAP_W'(DEPTH)) begin
      cfg_o.eff_cap = CAP_W'(DEPTH);
    end else begin
      cfg_o.eff_cap = capacity_q;
    end
    cfg_o.max_addr = max_addr_q;
  end

endmodule

`default_nettype wire

/* design/prq_core.sv */
// Queue engine: slot memory, head and tail pointers, fill count and beat counters.
// Reads the head slot on accept, then decides and writes back once the result is taken. Depends on prq_pkg.
`default_nettype none

module prq_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire prq_pkg::cfg_t cfg_i,
  input  wire logic          op_valid_i,
  input  wire prq_pkg::op_t  op_i,
  output logic               op_ready_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output prq_pkg::res_t      res_o
);
  import prq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e            state_q, state_d;
  op_t               op_q;
  slot_t             mem [DEPTH];
  slot_t             rdata_q;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CAP_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rx_q, rx_d, tx_q, tx_d;
  logic              accept, commit, wr_en, head_ok;
  status_e           status;
  slot_t             pkt;

  assign op_ready_o  = (state_q == S_IDLE);
  assign accept      = op_valid_i && op_ready_o;
  assign res_valid_o = (state_q == S_EXEC);
  assign commit      = res_valid_o && res_ready_i;
  assign head_ok     = addr_ok(rdata_q.src, cfg_i.max_addr) && addr_ok(rdata_q.dst, cfg_i.max_addr);

  always_comb begin
    status  = STATUS_OK;
    pkt     = '0;
    wr_en   = 1'b0;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    rx_d    = rx_q;
    tx_d    = tx_q;
    unique case (op_q.kind)
      KIND_ENQ: begin
        if (!addr_ok(op_q.pkt.src, cfg_i.max_addr) ||
            !addr_ok(op_q.pkt.dst, cfg_i.max_addr)) begin
          status = STATUS_BAD_ADDR;
        end else if (count_q >= cfg_i.eff_cap) begin
          status = STATUS_FULL;
        end else begin
          wr_en   = 1'b1;
          tail_d  = ptr_advance(tail_q, cfg_i.eff_cap);
          count_d = count_q + CAP_W'(1);
          rx_d    = rx_q + CNT_W'(1);
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (count_q == '0) begin
          status = STATUS_EMPTY;
        end else begin
          if (op_q.kind == KIND_DEQ) begin
            head_d  = ptr_advance(head_q, cfg_i.eff_cap);
            count_d = count_q - CAP_W'(1);
            tx_d    = tx_q + CNT_W'(1);
          end
          if (head_ok) begin
            pkt = rdata_q;
          end else begin
            status = STATUS_BAD_ADDR;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.status    = status;
  assign res_o.pkt       = pkt;
  assign res_o.occupancy = count_d;
  assign res_o.rx_count  = rx_d;
  assign res_o.tx_count  = tx_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      rx_q    <= '0;
      tx_q    <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
        rx_q    <= rx_d;
        tx_q    <= tx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && wr_en) begin
      mem[tail_q] <= op_q.pkt;
    end
    if (accept) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule

`default_nettype wire

/* design/packet_ring_queue.sv */
// Top level of the packet ring queue: configuration registers, queue engine, result register.
// Depends on prq_pkg, prq_cfg_regs and prq_core.
//
//   Channel  | Handshake                  | Payload
//   input    | in_valid_i / in_stall_o    | kind, src_addr, dst_addr, seq_no, hops
//   output   | out_valid_o / out_stall_i  | status, out_* packet, occupancy, counters
//   config   | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// Each operation has two steps: the slot memory read, then the decide and write-back.
// A new operation is accepted only after the previous result has moved into the result register.
// The result register holds a finished beat, so the engine can start the next one.
// Reset empties the queue and clears both counters; slot contents are kept.
// A stalled output holds its beat; the engine waits in its decide cycle until the register frees.
`default_nettype none

module packet_ring_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     kind_i,
  input  wire logic signed [7:0]              src_addr_i,
  input  wire logic signed [7:0]              dst_addr_i,
  input  wire logic [15:0]                    seq_no_i,
  input  wire logic [7:0]                     hops_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [7:0]                   out_src_addr_o,
  output logic signed [7:0]                   out_dst_addr_o,
  output logic [15:0]                         out_seq_no_o,
  output logic [7:0]                          out_hops_o,
  output logic [prq_pkg::CAP_W-1:0]           occupancy_o,
  output logic [prq_pkg::CNT_W-1:0]           received_count_o,
  output logic [prq_pkg::CNT_W-1:0]           transmitted_count_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [prq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [prq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import prq_pkg::*;

  cfg_t  cfg;
  op_t   op;
  res_t  res, out_q;
  logic  op_ready, res_valid, res_ready, out_valid_q, out_valid_d;

  prq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign op.kind    = kind_e'(kind_i);
  assign op.pkt.src = src_addr_i;
  assign op.pkt.dst = dst_addr_i;
  assign op.pkt.seq = seq_no_i;
  assign op.pkt.hop = hops_i;

  prq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_valid_i  (in_valid_i),
    .op_i        (op),
    .op_ready_o  (op_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign in_stall_o = !op_ready;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign out_src_addr_o      = out_q.pkt.src;
  assign out_dst_addr_o      = out_q.pkt.dst;
  assign out_seq_no_o        = out_q.pkt.seq;
  assign out_hops_o          = out_q.pkt.hop;
  assign occupancy_o         = out_q.occupancy;
  assign received_count_o    = out_q.rx_count;
  assign transmitted_count_o = out_q.tx_count;

endmodule

`default_nettype wire

/* design/prq_checker.sv */
// Port-level checks for the packet ring queue, attached to the top level by a bind.
// Depends on prq_pkg and packet_ring_queue.
`default_nettype none

module prq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [1:0]                   status_o,
  input wire logic [prq_pkg::CAP_W-1:0]    occupancy_o,
  input wire logic [prq_pkg::CNT_W-1:0]    received_count_o
);
  import prq_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("A second operation was accepted while one was in flight.");

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("A result beat appeared without a matching input beat.");

  a_empty_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_EMPTY) |-> (occupancy_o == '0))
    else $error("An empty status reported a nonzero occupancy.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
                                      && $stable(received_count_o)))
    else $error("A stalled output beat changed or vanished.");

endmodule

bind packet_ring_queue prq_checker u_prq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .occupancy_o      (occupancy_o),
  .received_count_o (received_count_o)
);

`default_nettype wire
